>>> sv/tms_pkg.sv
// tms_pkg: shared types and constants for the trackball motion scaler.
// Used by tms_cfg_regs, tms_mul_unit and trackball_motion_scaler.
package tms_pkg;

	localparam int SENS_SHIFT_DEF  = 6;
	localparam int VALUE_WIDTH_DEF = 16;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;
	localparam int KIND_W     = 3;
	localparam int OUT_W      = 16;
	localparam int DELTA_W    = 9;

	localparam logic [CFG_IDX_W-1:0] REG_FLIP_X      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FLIP_Y      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SENSITIVITY = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PTR_GAIN    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WHEEL_GAIN  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SCROLL_MODE = 3'd5;

	localparam logic [KIND_W-1:0] KIND_MOVE_X = 3'd0;
	localparam logic [KIND_W-1:0] KIND_MOVE_Y = 3'd1;
	localparam logic [KIND_W-1:0] KIND_HWHEEL = 3'd2;
	localparam logic [KIND_W-1:0] KIND_VWHEEL = 3'd3;
	localparam logic [KIND_W-1:0] KIND_BUTTON = 3'd4;

	localparam logic [7:0] SENS_RESET   = 8'd64;
	localparam logic [7:0] FACTOR_RESET = 8'd1;

	typedef struct packed {
		logic       flip_x;
		logic       flip_y;
		logic [7:0] sensitivity;
		logic [7:0] ptr_gain;
		logic [7:0] wheel_gain;
		logic       scroll_mode;
	} cfg_t;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_MX1  = 7'b0000010,
		ST_MX2  = 7'b0000100,
		ST_MY1  = 7'b0001000,
		ST_MY2  = 7'b0010000,
		ST_FIN  = 7'b0100000,
		ST_EMIT = 7'b1000000
	} state_t;

endpackage

>>> sv/tms_cfg_regs.sv
// tms_cfg_regs: configuration register file, plain write port.
// Depends on tms_pkg for cfg_t and register indexes.
module tms_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [tms_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tms_pkg::CFG_DATA_W-1:0] cfg_data,
	output tms_pkg::cfg_t                  cfg
);

	tms_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.flip_x      <= 1'b0;
			cfg_q.flip_y      <= 1'b0;
			cfg_q.sensitivity <= tms_pkg::SENS_RESET;
			cfg_q.ptr_gain    <= tms_pkg::FACTOR_RESET;
			cfg_q.wheel_gain  <= tms_pkg::FACTOR_RESET;
			cfg_q.scroll_mode <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				tms_pkg::REG_FLIP_X:      cfg_q.flip_x      <= cfg_data[0];
				tms_pkg::REG_FLIP_Y:      cfg_q.flip_y      <= cfg_data[0];
				tms_pkg::REG_SENSITIVITY: cfg_q.sensitivity <= cfg_data;
				tms_pkg::REG_PTR_GAIN:    cfg_q.ptr_gain    <= cfg_data;
				tms_pkg::REG_WHEEL_GAIN:  cfg_q.wheel_gain  <= cfg_data;
				tms_pkg::REG_SCROLL_MODE: cfg_q.scroll_mode <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> sv/tms_mul_unit.sv
// tms_mul_unit: shared signed-by-unsigned-byte multiplier, registered product.
// Takes its default width from tms_pkg; used by the trackball_motion_scaler sequencer.
module tms_mul_unit #(
	parameter int AW = tms_pkg::VALUE_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [AW-1:0] a,
	input  logic        [7:0]    b,
	output logic signed [AW+8:0] prod_q
);

	localparam int PW = AW + 9;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= PW'(a) * PW'($signed({1'b0, b}));
		end
	end

endmodule

>>> sv/trackball_motion_scaler.sv
// trackball_motion_scaler: top level, sequencer and event output register.
// Depends on tms_pkg, tms_cfg_regs and tms_mul_unit.
//
// One sample word enters on in_valid/in_ready; up to three event words
// leave on out_valid/out_ready, in the order x, y, button, the final one
// marked by last. Configuration is a plain write port (cfg_we, cfg_index,
// cfg_data) and must be written only while the block is idle; the block
// itself does not enforce this. A sample takes four passes through the one
// shared multiplier (x times sensitivity, x times factor, then the same
// for y), in states ST_MX1 to ST_MY2; ST_FIN then settles the event
// flags, and ST_EMIT loads the events one at a time. in_ready is high
// again once ST_EMIT finds no event pending and returns to ST_IDLE.
// A stalled receiver holds the output register; loading of further
// events waits, and no new sample is taken until all are loaded.
// Reset restores register defaults, clears the button state to released
// and empties the output register.
module trackball_motion_scaler #(
	parameter int SENS_SHIFT  = tms_pkg::SENS_SHIFT_DEF,
	parameter int VALUE_WIDTH = tms_pkg::VALUE_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [tms_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tms_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [7:0]                      count_left,
	input  logic [7:0]                      count_right,
	input  logic [7:0]                      count_up,
	input  logic [7:0]                      count_down,
	input  logic [7:0]                      switch_state,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [tms_pkg::KIND_W-1:0]      event_kind,
	output logic signed [tms_pkg::OUT_W-1:0] event_value,
	output logic                            sync,
	output logic                            last
);

	localparam int VW = VALUE_WIDTH;
	localparam int PW = VW + 9;
	localparam logic signed [PW-1:0] BIAS = PW'((64'd1 << SENS_SHIFT) - 64'd1);

	tms_pkg::cfg_t  cfg;
	tms_pkg::state_t state_q;

	logic signed [tms_pkg::DELTA_W-1:0] dx_q, dy_q;
	logic                               pressed_q, prev_q;
	logic signed [VW-1:0]               x_val_q, y_val_q;
	logic                               pend_x_q, pend_y_q, pend_b_q;

	logic                               out_valid_q, sync_q, last_q;
	logic [tms_pkg::KIND_W-1:0]         kind_q;
	logic signed [tms_pkg::OUT_W-1:0]   value_q;

	logic                               mul_en;
	logic signed [VW-1:0]               mul_a;
	logic [7:0]                         mul_b;
	logic signed [PW-1:0]               prod;
	logic signed [PW-1:0]               biased;
	logic signed [VW-1:0]               scaled;
	logic signed [VW-1:0]               prod_w;
	logic [7:0]                         factor;
	logic signed [tms_pkg::DELTA_W-1:0] dx_raw, dy_raw;
	logic                               can_load;

	tms_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	tms_mul_unit #(.AW(VW)) u_mul (
		.clk    (clk),
		.en     (mul_en),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod)
	);

	// divide by 2^SENS_SHIFT toward zero
	assign biased = prod + (prod[PW-1] ? BIAS : '0);
	assign scaled = VW'(biased >>> SENS_SHIFT);
	assign prod_w = VW'(prod);
	assign factor = cfg.scroll_mode ? cfg.wheel_gain : cfg.ptr_gain;

	assign dx_raw = $signed({1'b0, count_right}) - $signed({1'b0, count_left});
	assign dy_raw = $signed({1'b0, count_down}) - $signed({1'b0, count_up});

	always_comb begin
		mul_en = 1'b1;
		mul_a  = '0;
		mul_b  = '0;
		case (state_q)
			tms_pkg::ST_MX1: begin
				mul_a = VW'(dx_q);
				mul_b = cfg.sensitivity;
			end
			tms_pkg::ST_MX2: begin
				mul_a = scaled;
				mul_b = factor;
			end
			tms_pkg::ST_MY1: begin
				mul_a = VW'(dy_q);
				mul_b = cfg.sensitivity;
			end
			tms_pkg::ST_MY2: begin
				mul_a = scaled;
				mul_b = factor;
			end
			default: mul_en = 1'b0;
		endcase
	end

	assign can_load = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tms_pkg::ST_IDLE;
			prev_q      <= 1'b0;
			pend_x_q    <= 1'b0;
			pend_y_q    <= 1'b0;
			pend_b_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == tms_pkg::ST_EMIT && can_load &&
					(pend_x_q || pend_y_q || pend_b_q)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				tms_pkg::ST_IDLE: begin
					if (in_valid) begin
						state_q <= tms_pkg::ST_MX1;
					end
				end
				tms_pkg::ST_MX1: state_q <= tms_pkg::ST_MX2;
				tms_pkg::ST_MX2: state_q <= tms_pkg::ST_MY1;
				tms_pkg::ST_MY1: state_q <= tms_pkg::ST_MY2;
				tms_pkg::ST_MY2: state_q <= tms_pkg::ST_FIN;
				tms_pkg::ST_FIN: begin
					pend_x_q <= x_val_q != '0;
					pend_y_q <= prod_w != '0;
					pend_b_q <= pressed_q != prev_q;
					prev_q   <= pressed_q;
					state_q  <= tms_pkg::ST_EMIT;
				end
				tms_pkg::ST_EMIT: begin
					if (!pend_x_q && !pend_y_q && !pend_b_q) begin
						state_q <= tms_pkg::ST_IDLE;
					end else if (can_load) begin
						if (pend_x_q) begin
							pend_x_q <= 1'b0;
						end else if (pend_y_q) begin
							pend_y_q <= 1'b0;
						end else begin
							pend_b_q <= 1'b0;
						end
					end
				end
				default: state_q <= tms_pkg::ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == tms_pkg::ST_IDLE && in_valid) begin
			dx_q      <= cfg.flip_x ? -dx_raw : dx_raw;
			dy_q      <= cfg.flip_y ? -dy_raw : dy_raw;
			pressed_q <= switch_state != 8'd0;
		end
		if (state_q == tms_pkg::ST_MY1) begin
			x_val_q <= prod_w;
		end
		if (state_q == tms_pkg::ST_FIN) begin
			y_val_q <= prod_w;
		end
		if (state_q == tms_pkg::ST_EMIT && can_load) begin
			if (pend_x_q) begin
				kind_q  <= cfg.scroll_mode ? tms_pkg::KIND_HWHEEL : tms_pkg::KIND_MOVE_X;
				value_q <= tms_pkg::OUT_W'(x_val_q);
				sync_q  <= !pend_y_q;
				last_q  <= !pend_y_q && !pend_b_q;
			end else if (pend_y_q) begin
				kind_q  <= cfg.scroll_mode ? tms_pkg::KIND_VWHEEL : tms_pkg::KIND_MOVE_Y;
				value_q <= tms_pkg::OUT_W'(y_val_q);
				sync_q  <= 1'b1;
				last_q  <= !pend_b_q;
			end else if (pend_b_q) begin
				kind_q  <= tms_pkg::KIND_BUTTON;
				value_q <= tms_pkg::OUT_W'({1'b0, prev_q});
				sync_q  <= 1'b1;
				last_q  <= 1'b1;
			end
		end
	end

	assign in_ready    = state_q == tms_pkg::ST_IDLE;
	assign out_valid   = out_valid_q;
	assign event_kind  = kind_q;
	assign event_value = value_q;
	assign sync        = sync_q;
	assign last        = last_q;

endmodule
